// File: design/oaht_pkg.sv
// Package for the open-address hash table: widths, slot codes, kinds, status codes.
// No dependencies.
`timescale 1ns / 1ps
package oaht_pkg;
    localparam int MAX_SLOTS = 1024;
    localparam int KEY_BITS  = 32;
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int MAG_W     = KEY_BITS;

    localparam logic [1:0] SLOT_EMPTY    = 2'd0;
    localparam logic [1:0] SLOT_OCCUPIED = 2'd1;
    localparam logic [1:0] SLOT_DELETED  = 2'd2;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [0:0] CFG_SIZE = 1'b0;
    localparam logic [0:0] CFG_STEP = 1'b1;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_mod_req;
endpackage

// File: design/oaht_mod.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on oaht_pkg.
`timescale 1ns / 1ps
module oaht_mod import oaht_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mod_req         i_req,
    output logic             o_done,
    output logic [CNT_W-1:0] o_rem
);
    localparam int STEP_W = $clog2(MAG_W + 1);
    logic [MAG_W-1:0]  r_num, n_num;
    logic [CNT_W:0]    r_rem, n_rem;
    logic [CNT_W-1:0]  r_div;
    logic [STEP_W-1:0] r_left, n_left;
    logic              r_busy, n_busy, r_done, n_done;
    logic [CNT_W:0]    w_sh;

    always_comb begin
        n_num = r_num; n_rem = r_rem; n_left = r_left; n_busy = r_busy; n_done = 1'b0;
        w_sh = {r_rem[CNT_W-1:0], r_num[MAG_W-1]};
        if (i_req.start) begin
            n_num = i_req.dividend; n_rem = '0;
            n_left = STEP_W'(MAG_W); n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[MAG_W-2:0], 1'b0};
            n_rem = (w_sh >= {1'b0, r_div}) ? w_sh - {1'b0, r_div} : w_sh;
            n_left = r_left - 1'b1;
            if (r_left == STEP_W'(1)) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_num <= n_num; r_rem <= n_rem; r_left <= n_left;
        if (i_req.start) r_div <= i_req.divisor;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[CNT_W-1:0];
endmodule

// File: design/open_address_hash_table.sv
// Top level of the open-address hash table: control FSM, key and slot-state memories.
// Depends on oaht_pkg and oaht_mod.
`timescale 1ns / 1ps
// Usage:
//  s_axis: one word per operation, tuser = kind (0 insert, 1 find, 2 delete),
//    tdata = key (32-bit signed).
//  m_axis: one word per operation, tdata = status, slot_index, stored_count,
//    probe_count, from the lowest bit up.
//  cfg: i_cfg_valid/o_cfg_ready with index (0 table_size, 1 probe_step) and data;
//    write only while idle.
// Sequence: two remainders on the divider unit (step mod size, then key mod size),
//  one quotient bit per cycle each; then, per probed slot, a memory read, then
//  check and write-back. One operation is in flight at a time.
// Reset: after i_rst_n rises the slot-state memory is swept to empty, one entry
//  per cycle over every entry, with s_axis tready low. Config resets to size 1021, step 1.
// Stall: the result sits in an output register; the block takes no new word
//  until it is taken.
module open_address_hash_table import oaht_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [31:0]         s_axis_tdata,  // key
    input  logic [1:0]          s_axis_tuser,  // kind
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [39:0]         m_axis_tdata,  // status, slot_index, stored_count, probe_count, pad
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [0:0]          i_cfg_index,
    input  logic [10:0]         i_cfg_data
);
    localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_MSTEP = 3'd2, S_MKEY = 3'd3,
                           S_RD = 3'd4, S_CHK = 3'd5, S_OUT = 3'd6;

    logic [2:0]          r_st;
    logic [CNT_W-1:0]    r_cfg_size;
    logic [IDX_W-1:0]    r_cfg_step;
    logic [CNT_W-1:0]    r_size;     // active size
    logic [IDX_W-1:0]    r_step;     // step mod size
    logic [IDX_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_probes, r_total;
    logic [1:0]          r_kind;
    logic [KEY_BITS-1:0] r_key;
    logic [IDX_W-1:0]    r_clr;
    logic                r_mod_go;
    logic [1:0]          r_status;
    logic [IDX_W-1:0]    r_slot;

    logic [KEY_BITS-1:0] m_key [MAX_SLOTS];
    logic [1:0]          m_state [MAX_SLOTS];
    logic [KEY_BITS-1:0] r_rd_key;
    logic [1:0]          r_rd_st;

    t_mod_req         w_req;
    logic             w_mdone;
    logic [CNT_W-1:0] w_rem;
    logic [KEY_BITS-1:0] w_mag;
    logic [CNT_W:0]   w_nx;
    logic [IDX_W-1:0] w_next;
    logic             w_st_we;
    logic [IDX_W-1:0] w_st_addr;
    logic [1:0]       w_st_d;

    assign w_mag = r_key[KEY_BITS-1] ? (~r_key + 1'b1) : r_key;
    assign w_nx  = {1'b0, {1'b0, r_idx} + {1'b0, r_step}};
    assign w_next = (w_nx >= {1'b0, r_size}) ? IDX_W'(w_nx - {1'b0, r_size})
                                             : IDX_W'(w_nx);

    always_comb begin
        w_req.start    = r_mod_go;
        w_req.divisor  = r_size;
        w_req.dividend = (r_st == S_MSTEP) ? MAG_W'(r_cfg_step) : w_mag;
    end

    oaht_mod u_mod (.i_clk, .i_rst_n, .i_req(w_req), .o_done(w_mdone), .o_rem(w_rem));

    assign s_axis_tready = (r_st == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = (r_st == S_OUT);
    assign m_axis_tdata  = {6'd0, r_probes, r_total, r_slot, r_status};

    // slot-state write: clear sweep or check-stage update
    always_comb begin
        w_st_we = 1'b0; w_st_addr = r_idx; w_st_d = SLOT_OCCUPIED;
        if (r_st == S_CLR) begin
            w_st_we = 1'b1; w_st_addr = r_clr; w_st_d = SLOT_EMPTY;
        end else if (r_st == S_CHK) begin
            if (r_kind == KIND_INSERT) begin
                w_st_we = (r_rd_st != SLOT_OCCUPIED);
            end else if (r_kind == KIND_DELETE) begin
                w_st_we = (r_rd_st == SLOT_OCCUPIED) && (r_rd_key == r_key);
                w_st_d  = SLOT_DELETED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_st_we) m_state[w_st_addr] <= w_st_d;
        if (r_st == S_CHK && r_kind == KIND_INSERT && r_rd_st != SLOT_OCCUPIED)
            m_key[r_idx] <= r_key;
        r_rd_st  <= m_state[r_idx];
        r_rd_key <= m_key[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_clr <= '0; r_total <= '0; r_mod_go <= 1'b0;
            r_cfg_size <= CNT_W'(1021); r_cfg_step <= IDX_W'(1);
        end else begin
            r_mod_go <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SIZE: r_cfg_size <= i_cfg_data;
                    CFG_STEP: r_cfg_step <= i_cfg_data[IDX_W-1:0];
                    default:  r_cfg_step <= r_cfg_step;
                endcase
            end
            case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == IDX_W'(MAX_SLOTS - 1)) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_key <= s_axis_tdata; r_kind <= s_axis_tuser;
                        r_size <= (r_cfg_size == '0) ? CNT_W'(1) :
                                  (r_cfg_size > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                                   : r_cfg_size;
                        r_mod_go <= 1'b1; r_st <= S_MSTEP;
                    end
                end
                S_MSTEP: if (w_mdone) begin
                    r_step <= IDX_W'(w_rem); r_mod_go <= 1'b1; r_st <= S_MKEY;
                end
                S_MKEY: if (w_mdone) begin
                    r_idx <= IDX_W'(w_rem); r_probes <= '0; r_st <= S_RD;
                end
                S_RD: r_st <= S_CHK;
                S_CHK: begin
                    r_probes <= r_probes + 1'b1;
                    r_status <= ST_NOTFOUND; r_slot <= '0; r_st <= S_OUT;
                    if (r_kind == KIND_INSERT) begin
                        if (r_rd_st != SLOT_OCCUPIED) begin
                            r_status <= ST_DONE; r_slot <= r_idx; r_total <= r_total + 1'b1;
                        end else if (r_probes + 1'b1 == r_size) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_idx <= w_next; r_st <= S_RD;
                        end
                    end else begin
                        if (r_rd_st == SLOT_EMPTY) begin
                            r_st <= S_OUT;
                        end else if (r_rd_st == SLOT_OCCUPIED && r_rd_key == r_key) begin
                            r_status <= ST_DONE; r_slot <= r_idx;
                            if (r_kind == KIND_DELETE && r_total != '0)
                                r_total <= r_total - 1'b1;
                        end else if (r_probes + 1'b1 != r_size) begin
                            r_idx <= w_next; r_st <= S_RD;
                        end
                    end
                end
                S_OUT: if (m_axis_tready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
